FILE: rtl/roihist_pkg.sv
// Package: types, codes and defaults shared by the ROI histogram statistics block
`timescale 1ns / 1ps
package roihist_pkg;

	localparam int DEF_MAX_BINS = 256;

	localparam logic signed [15:0] RST_HIST_LOW  = -16'sd1024;
	localparam logic signed [15:0] RST_HIST_HIGH = 16'sd3071;
	localparam logic [8:0]         RST_BINS      = 9'd256;
	localparam logic signed [15:0] RST_MIN       = 16'sh7FFF;
	localparam logic signed [15:0] RST_MAX       = -16'sh8000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_HIST_LOW  = 2'd0,
		CFG_HIST_HIGH = 2'd1,
		CFG_BINS      = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_HRD,
		ST_HWR,
		ST_RRD,
		ST_RCAP
	} state_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] voxel_value;
		logic [7:0]         read_bin;
	} req_t;

	typedef struct packed {
		logic [31:0]        voxel_count;
		logic signed [15:0] min_value;
		logic signed [15:0] max_value;
		logic signed [47:0] value_sum;
		logic [62:0]        square_sum;
		logic [31:0]        bin_value;
		logic               empty_res;
	} res_t;

	typedef struct packed {
		logic capture;
		logic clr_stats;
		logic walk_step;
		logic mul;
		logic acc;
		logic div_step;
		logic hist_rd;
		logic hist_wr;
		logic res_rd;
		logic res_cap;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic walk_last;
		logic div_last;
	} sts_t;

endpackage

FILE: rtl/roihist_ram.sv
// Generic single write port, single read port RAM with registered read data
`timescale 1ns / 1ps
module roihist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/roihist_ctrl.sv
// Controller state machine: sequences clear walks, stat updates, bin division and reads
`timescale 1ns / 1ps
module roihist_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	input  roihist_pkg::sts_t  sts,
	output roihist_pkg::cmd_t  cmd,
	output logic               busy
);

	roihist_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= roihist_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			roihist_pkg::ST_INIT: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = roihist_pkg::ST_IDLE;
				end
			end
			roihist_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					case (opcode)
						roihist_pkg::OP_CLEAR: begin
							cmd.clr_stats = 1'b1;
							state_d       = roihist_pkg::ST_CLEAR;
						end
						roihist_pkg::OP_ADD: begin
							state_d = roihist_pkg::ST_MUL;
						end
						default: begin
							state_d = roihist_pkg::ST_RRD;
						end
					endcase
				end
			end
			roihist_pkg::ST_CLEAR: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = roihist_pkg::ST_RRD;
				end
			end
			roihist_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = roihist_pkg::ST_ACC;
			end
			roihist_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.in_range ? roihist_pkg::ST_DIV : roihist_pkg::ST_RRD;
			end
			roihist_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = roihist_pkg::ST_HRD;
				end
			end
			roihist_pkg::ST_HRD: begin
				cmd.hist_rd = 1'b1;
				state_d     = roihist_pkg::ST_HWR;
			end
			roihist_pkg::ST_HWR: begin
				cmd.hist_wr = 1'b1;
				state_d     = roihist_pkg::ST_RRD;
			end
			roihist_pkg::ST_RRD: begin
				cmd.res_rd = 1'b1;
				state_d    = roihist_pkg::ST_RCAP;
			end
			roihist_pkg::ST_RCAP: begin
				cmd.res_cap = 1'b1;
				state_d     = roihist_pkg::ST_IDLE;
			end
			default: begin
				state_d = roihist_pkg::ST_INIT;
			end
		endcase
	end

	assign busy = (state_q != roihist_pkg::ST_IDLE);

endmodule

FILE: rtl/roihist_dp.sv
// Datapath: config registers, running statistics, bin divider and histogram memory
`timescale 1ns / 1ps
module roihist_dp #(
	parameter int MAX_BINS = roihist_pkg::DEF_MAX_BINS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  roihist_pkg::req_t  request,
	input  roihist_pkg::cmd_t  cmd,
	output roihist_pkg::sts_t  sts,
	input  logic               cfg_wr,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output roihist_pkg::res_t  result,
	output logic               done
);

	localparam int AW  = $clog2(MAX_BINS);
	localparam int BW  = $clog2(MAX_BINS + 1);
	localparam int PW  = 16 + BW;
	localparam int DCW = $clog2(BW);

	logic signed [15:0] hist_low_q, hist_high_q;
	logic [8:0]         bins_q;

	roihist_pkg::req_t  req_q;
	logic [31:0]        count_q;
	logic signed [15:0] min_q, max_q;
	logic signed [47:0] sum_q;
	logic [62:0]        square_q;

	logic [31:0]        sq_s1;
	logic [PW-1:0]      prod_s1;
	logic               in_range_s1;

	logic [15:0]        rem_q;
	logic [BW-1:0]      low_q, quo_q;
	logic [DCW-1:0]     div_cnt_q;
	logic [AW-1:0]      walk_q;

	roihist_pkg::res_t  res_q;
	logic               done_q;

	logic [BW-1:0]      bins_eff;
	logic signed [15:0] v;
	logic signed [31:0] v32;
	logic signed [16:0] off_full, span_full;
	logic [15:0]        off, span;
	logic               in_range;
	logic signed [48:0] sum_ext;
	logic [63:0]        sq_ext;
	logic [16:0]        trial;
	logic               qbit;
	logic [BW-1:0]      bin_sel;
	logic [AW-1:0]      bin_addr, rb_addr;
	logic               rb_ok;
	logic               walk_last;

	logic               ram_wr_en, ram_rd_en;
	logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
	logic [31:0]        ram_wr_data, ram_rd_data;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_low_q  <= roihist_pkg::RST_HIST_LOW;
			hist_high_q <= roihist_pkg::RST_HIST_HIGH;
			bins_q      <= roihist_pkg::RST_BINS;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				roihist_pkg::CFG_HIST_LOW:  hist_low_q  <= $signed(cfg_data);
				roihist_pkg::CFG_HIST_HIGH: hist_high_q <= $signed(cfg_data);
				roihist_pkg::CFG_BINS:      bins_q      <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bins_q == 9'd0) begin
			bins_eff = BW'(1);
		end else if (32'(bins_q) > 32'(MAX_BINS)) begin
			bins_eff = BW'(MAX_BINS);
		end else begin
			bins_eff = BW'(bins_q);
		end
	end

	assign v         = req_q.voxel_value;
	assign v32       = 32'(v);
	assign off_full  = 17'(v) - 17'(hist_low_q);
	assign span_full = 17'(hist_high_q) - 17'(hist_low_q);
	assign off       = off_full[15:0];
	assign span      = span_full[15:0];
	assign in_range  = (hist_high_q > hist_low_q) && (v >= hist_low_q) && (v <= hist_high_q);

	assign sum_ext = 49'(sum_q) + 49'(v);
	assign sq_ext  = {1'b0, square_q} + 64'(sq_s1);

	assign trial = {rem_q, low_q[BW-1]};
	assign qbit  = (trial >= {1'b0, span});

	assign bin_sel  = (quo_q >= bins_eff) ? (bins_eff - BW'(1)) : quo_q;
	assign bin_addr = AW'(bin_sel);
	assign rb_addr  = AW'(req_q.read_bin);
	assign rb_ok    = (32'(req_q.read_bin) < 32'(MAX_BINS));

	assign walk_last = (walk_q == AW'(MAX_BINS - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (cmd.mul) begin
			sq_s1       <= v32 * v32;
			prod_s1     <= {{BW{1'b0}}, off} * {16'b0, bins_eff};
			in_range_s1 <= in_range;
		end
		if (cmd.acc) begin
			rem_q     <= prod_s1[PW-1:BW];
			low_q     <= prod_s1[BW-1:0];
			quo_q     <= '0;
			div_cnt_q <= DCW'(BW - 1);
		end else if (cmd.div_step) begin
			if (qbit) begin
				rem_q <= 16'(trial - {1'b0, span});
			end else begin
				rem_q <= trial[15:0];
			end
			low_q     <= low_q << 1;
			quo_q     <= {quo_q[BW-2:0], qbit};
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	// running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			min_q    <= roihist_pkg::RST_MIN;
			max_q    <= roihist_pkg::RST_MAX;
			sum_q    <= '0;
			square_q <= '0;
		end else if (cmd.clr_stats) begin
			count_q  <= '0;
			min_q    <= roihist_pkg::RST_MIN;
			max_q    <= roihist_pkg::RST_MAX;
			sum_q    <= '0;
			square_q <= '0;
		end else if (cmd.acc) begin
			if (count_q != '1) begin
				count_q <= count_q + 32'd1;
			end
			if (v < min_q) begin
				min_q <= v;
			end
			if (v > max_q) begin
				max_q <= v;
			end
			if (sum_ext[48] != sum_ext[47]) begin
				sum_q <= sum_ext[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
			end else begin
				sum_q <= sum_ext[47:0];
			end
			square_q <= sq_ext[63] ? '1 : sq_ext[62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (cmd.walk_step) begin
			walk_q <= walk_last ? '0 : walk_q + AW'(1);
		end
	end

	// histogram memory
	assign ram_wr_en   = cmd.walk_step | cmd.hist_wr;
	assign ram_wr_addr = cmd.walk_step ? walk_q : bin_addr;
	assign ram_wr_data = cmd.walk_step ? 32'd0 :
		((ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 32'd1);
	assign ram_rd_en   = cmd.hist_rd | cmd.res_rd;
	assign ram_rd_addr = cmd.res_rd ? rb_addr : bin_addr;

	roihist_ram #(
		.WIDTH (32),
		.DEPTH (MAX_BINS)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// result
	always_ff @(posedge clk) begin
		if (cmd.res_cap) begin
			res_q.voxel_count <= count_q;
			res_q.min_value   <= (count_q == '0) ? 16'sd0 : min_q;
			res_q.max_value   <= (count_q == '0) ? 16'sd0 : max_q;
			res_q.value_sum   <= sum_q;
			res_q.square_sum  <= square_q;
			res_q.bin_value   <= rb_ok ? ram_rd_data : 32'd0;
			res_q.empty_res   <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_cap;
		end
	end

	assign sts.in_range  = in_range_s1;
	assign sts.walk_last = walk_last;
	assign sts.div_last  = (div_cnt_q == '0);

	assign result = res_q;
	assign done   = done_q;

endmodule

FILE: rtl/roi_intensity_histogram_stats.sv
// Top level: ROI intensity statistics with histogram, controller plus datapath
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy             request (req_t)
//  result    out        done, one cycle strobe    result (res_t)
//  config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Add voxel in range: MUL, ACC, the bit-serial bin divider over BW = clog2(MAX_BINS+1) quotient
// bits, then the read-modify-write of the bin memory, then the result read and capture.
// Add outside the range: MUL, ACC, then result read and capture. Read: result read and capture.
// Clear: all bins zeroed, one bin a cycle, then result read and capture. After reset the bin
// memory is zeroed with busy high. The receiver cannot stall; config writes are always taken.
`timescale 1ns / 1ps
module roi_intensity_histogram_stats #(
	parameter int MAX_BINS = roihist_pkg::DEF_MAX_BINS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  roihist_pkg::req_t request,
	output logic              done,
	output roihist_pkg::res_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	roihist_pkg::cmd_t cmd;
	roihist_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	roihist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	roihist_dp #(
		.MAX_BINS (MAX_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.done      (done)
	);

endmodule

FILE: sim/roi_intensity_histogram_stats_test.sv
// Testbench: randomised request stream against an in-bench model of the ROI histogram statistics
`timescale 1ns / 1ps
module roi_intensity_histogram_stats_test;
	import roihist_pkg::*;

	localparam logic [1:0] OP_SPARE     = 2'd3;
	localparam int         PHASES       = 9;
	localparam int         PER_PHASE    = 48;
	localparam int         LIMIT_CYCLES = 600000;

	class roi_stats_board;
		localparam longint          SUM_TOP = 64'sh7FFF_FFFF_FFFF;
		localparam longint          SUM_BOT = -SUM_TOP - 1;
		localparam longint unsigned SQ_TOP  = 64'h7FFF_FFFF_FFFF_FFFF;

		bit [31:0]          bin_count [DEF_MAX_BINS];
		bit [31:0]          voxels;
		int                 vmin;
		int                 vmax;
		longint             vsum;
		longint unsigned    sqsum;
		logic signed [15:0] lo_reg;
		logic signed [15:0] hi_reg;
		logic [8:0]         bins_reg;
		res_t               due_stats [$];
		int                 errors;
		int                 requests;
		int                 clears;
		int                 adds;
		int                 results;

		function new();
			lo_reg   = RST_HIST_LOW;
			hi_reg   = RST_HIST_HIGH;
			bins_reg = RST_BINS;
			clear_all();
		endfunction

		function void clear_all();
			foreach (bin_count[i])
				bin_count[i] = '0;
			voxels = '0;
			vmin   = 32767;
			vmax   = -32768;
			vsum   = 0;
			sqsum  = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] d);
			case (idx)
				CFG_HIST_LOW:  lo_reg = d;
				CFG_HIST_HIGH: hi_reg = d;
				CFG_BINS:      bins_reg = d[8:0];
				default: ;
			endcase
		endfunction

		// bin a voxel lands in, or -1 when the histogram skips it
		function int bin_of(int v);
			int     lo;
			int     hi;
			int     nb;
			longint q;
			lo = lo_reg;
			hi = hi_reg;
			if (hi <= lo || v < lo || v > hi)
				return -1;
			nb = bins_reg;
			if (nb == 0)
				nb = 1;
			if (nb > DEF_MAX_BINS)
				nb = DEF_MAX_BINS;
			q = longint'(v - lo) * nb / (hi - lo);
			if (q >= nb)
				q = nb - 1;
			return int'(q);
		endfunction

		function void take_request(req_t r);
			res_t            e;
			int              v;
			int              b;
			longint unsigned sq;
			requests++;
			v = r.voxel_value;
			case (r.opcode)
				OP_CLEAR: begin
					clear_all();
					clears++;
				end
				OP_ADD: begin
					adds++;
					if (voxels != '1)
						voxels++;
					if (v < vmin)
						vmin = v;
					if (v > vmax)
						vmax = v;
					vsum += v;
					if (vsum > SUM_TOP)
						vsum = SUM_TOP;
					if (vsum < SUM_BOT)
						vsum = SUM_BOT;
					sq = longint'(v) * longint'(v);
					if (sqsum > SQ_TOP - sq)
						sqsum = SQ_TOP;
					else
						sqsum += sq;
					b = bin_of(v);
					if (b >= 0 && bin_count[b] != '1)
						bin_count[b]++;
				end
				default: ;
			endcase
			e.voxel_count = voxels;
			e.empty_res   = (voxels == 0);
			e.min_value   = e.empty_res ? 16'sd0 : 16'(vmin);
			e.max_value   = e.empty_res ? 16'sd0 : 16'(vmax);
			e.value_sum   = vsum[47:0];
			e.square_sum  = sqsum[62:0];
			e.bin_value   = bin_count[r.read_bin];
			due_stats.insert(due_stats.size(), e);
		endfunction

		function void cmp(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns %s mismatch: expected %h, got %h", $time, field, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t e;
			results++;
			if (due_stats.size() == 0) begin
				errors++;
				$display("%0t ns result with no request outstanding: %h", $time, got);
				return;
			end
			e = due_stats.pop_front();
			cmp("voxel_count", e.voxel_count, got.voxel_count);
			cmp("min_value", e.min_value, got.min_value);
			cmp("max_value", e.max_value, got.max_value);
			cmp("value_sum", e.value_sum, got.value_sum);
			cmp("square_sum", e.square_sum, got.square_sum);
			cmp("bin_value", e.bin_value, got.bin_value);
			cmp("empty_res", e.empty_res, got.empty_res);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	logic        done;
	res_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	roi_stats_board board = new();
	bit             gaps_off;
	int             last_bin;
	int             cycles;

	roi_intensity_histogram_stats dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("roi_intensity_histogram_stats_test NOT OK");
			$finish;
		end
	end

	task automatic issue(input logic [1:0] op, input logic signed [15:0] v,
		input logic [7:0] rb);
		req_t r;
		int   gap;
		int   b;
		r.opcode      = op;
		r.voxel_value = v;
		r.read_bin    = rb;
		gap = gaps_off ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		board.take_request(r);
		if (op == OP_ADD) begin
			b = board.bin_of(v);
			if (b >= 0)
				last_bin = b;
		end
	endtask

	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (board.due_stats.size() != 0 || busy);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [15:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly in-range values, with the range edges and anything at all mixed in
	function automatic logic signed [15:0] pick_voxel();
		int lo;
		int hi;
		int sel;
		lo  = board.lo_reg;
		hi  = board.hi_reg;
		sel = $urandom_range(0, 9);
		if (hi > lo && sel < 6)
			return 16'(lo + int'($urandom_range(0, hi - lo)));
		case (sel)
			6: return 16'(lo);
			7: return 16'(hi);
			8: return ($urandom_range(0, 1) != 0) ? 16'(lo - 1) : 16'(hi + 1);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int         lo;
		int         hi;
		int         nb;
		int         sel;
		logic [1:0] op;
		logic [7:0] rb;
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HIST_LOW;
		cfg_data  = '0;
		cycles    = 0;
		last_bin  = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		quiesce();

		// default range [-1024, 3071] over 256 bins
		issue(OP_READ, 16'sd0, 8'd0);
		issue(OP_SPARE, 16'sd0, 8'd255);
		issue(OP_ADD, -16'sd1024, 8'd0);
		issue(OP_ADD, 16'sd3071, 8'd255);
		issue(OP_ADD, -16'sd32768, 8'd0);
		issue(OP_ADD, 16'sd32767, 8'd255);
		issue(OP_ADD, -16'sd1025, 8'd0);
		issue(OP_ADD, 16'sd3072, 8'd255);
		issue(OP_ADD, 16'sd0, 8'd64);
		issue(OP_ADD, -16'sd1, 8'd63);
		issue(OP_READ, 16'sh5555, 8'd64);
		issue(OP_SPARE, 16'shAAAA, 8'd170);
		issue(OP_READ, 16'sd0, 8'd85);
		issue(OP_CLEAR, 16'sh7FFF, 8'd0);
		issue(OP_READ, 16'sd0, 8'd64);
		issue(OP_ADD, 16'sh5555, 8'd0);
		issue(OP_ADD, 16'shAAAA, 8'd0);
		issue(OP_CLEAR, -16'sd1, 8'd255);
		issue(OP_ADD, 16'sd7, 8'd66);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin lo = -32768; hi = 32767; nb = 256; end
				1: begin lo = -32768; hi = 32767; nb = 1; end
				2: begin lo = 0; hi = 1; nb = 256; end
				3: begin lo = -10; hi = 10; nb = 7; end
				4: begin lo = 100; hi = 100; nb = 0; end
				5: begin lo = 500; hi = -500; nb = 511; end
				6: begin lo = -1024; hi = 3071; nb = 256; end
				7: begin lo = $urandom; hi = $urandom; nb = $urandom; end
				default: begin
					lo = int'($urandom_range(0, 40000)) - 32768;
					hi = lo + int'($urandom_range(1, 25000));
					nb = $urandom_range(1, 256);
				end
			endcase
			quiesce();
			write_cfg(CFG_HIST_LOW, 16'(lo));
			write_cfg(CFG_HIST_HIGH, 16'(hi));
			write_cfg(CFG_BINS, 16'(nb));
			gaps_off = ($urandom_range(0, 3) == 0);
			last_bin = 0;
			repeat (PER_PHASE) begin
				sel = $urandom_range(0, 99);
				if (sel < 3)
					op = OP_CLEAR;
				else if (sel < 73)
					op = OP_ADD;
				else if (sel < 93)
					op = OP_READ;
				else
					op = OP_SPARE;
				rb = ($urandom_range(0, 2) != 0) ? 8'(last_bin) : 8'($urandom);
				issue(op, pick_voxel(), rb);
			end
		end

		quiesce();
		repeat (24) @(posedge clk);
		$display("%0d requests (%0d adds, %0d clears), %0d results checked",
			board.requests, board.adds, board.clears, board.results);
		$display("histogram settings: reset default plus %0d written, incl. full, empty and inverted",
			PHASES);
		if (board.errors == 0 && board.due_stats.size() == 0)
			$display("roi_intensity_histogram_stats_test OK");
		else
			$display("roi_intensity_histogram_stats_test NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/roihist_pkg.sv
rtl/roihist_ram.sv
rtl/roihist_ctrl.sv
rtl/roihist_dp.sv
rtl/roi_intensity_histogram_stats.sv
sim/roi_intensity_histogram_stats_test.sv
